>>> hdl/bbvic_pkg.sv
// Shared types, constants and codes for the basic block vector interval counter.
package bbvic_pkg;

	localparam int NUM_BLOCKS_DEF = 64;
	localparam int ID_W           = 6;
	localparam int INSN_W         = 12;
	localparam int LEN_W          = 40;
	localparam int CNT_W          = 41;
	localparam int INUM_W         = 32;
	localparam int APB_AW         = 4;
	localparam int APB_DW         = 64;

	localparam logic [LEN_W-1:0] INTERVAL_RESET = LEN_W'(100000000);

	localparam logic REG_INTERVAL_LENGTH = 1'b0;

	localparam logic CMD_EVENT  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [ID_W-1:0]   block_id;
		logic [INSN_W-1:0] insn_count;
	} item_t;

	typedef struct packed {
		logic [INUM_W-1:0] interval_number;
		logic [ID_W-1:0]   entry_id;
		logic [CNT_W-1:0]  entry_count;
		logic              last_entry;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic load_ev;
		logic write_ev;
		logic scan;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic id_in_range;
		logic any_present;
		logic reached;
		logic scan_last;
	} dp_sts_t;

endpackage

>>> hdl/bbvic_ram.sv
// Generic single write port RAM with registered read.
module bbvic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/bbvic_ctrl.sv
// Controller state machine: event update, interval dump sequencing.
module bbvic_ctrl
	import bbvic_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    cmd,
	input  dp_sts_t sts,
	output logic    busy,
	output dp_cmd_t dcmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dcmd    = '0;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (cmd == CMD_EVENT) begin
						// drop events for blocks beyond the histogram
						if (sts.id_in_range) begin
							dcmd.load_ev = 1'b1;
							state_d      = ST_UPDATE;
						end
					end else if (sts.any_present) begin
						state_d = ST_DUMP;
					end
				end
			end
			ST_UPDATE: begin
				dcmd.write_ev = 1'b1;
				state_d       = sts.reached ? ST_DUMP : ST_IDLE;
			end
			ST_DUMP: begin
				dcmd.scan = 1'b1;
				if (sts.scan_last) begin
					dcmd.finish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/bbvic_dp.sv
// Datapath: histogram store, present flags, interval total, scan and result stage.
module bbvic_dp
	import bbvic_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            item,
	input  dp_cmd_t          dcmd,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	output logic [LEN_W-1:0] length,
	output dp_sts_t          sts,
	output logic             strobe,
	output result_t          result
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);

	logic [LEN_W-1:0]      length_q;
	logic [CNT_W-1:0]      total_q;
	logic [INUM_W-1:0]     inum_q;
	logic [NUM_BLOCKS-1:0] present_q;

	logic [IDX_W-1:0]  ev_id_q;
	logic [INSN_W-1:0] ev_cnt_q;
	logic              ev_pres_q;

	logic              strobe_s1;
	logic [ID_W-1:0]   id_s1;
	logic              last_s1;
	logic [INUM_W-1:0] inum_s1;

	logic [IDX_W-1:0]      in_idx;
	logic [NUM_BLOCKS-1:0] low_bit;
	logic [NUM_BLOCKS-1:0] pend_rest;
	logic [IDX_W-1:0]      scan_idx;
	logic [IDX_W-1:0]      raddr;
	logic                  re;
	logic [CNT_W-1:0]      rdata;
	logic [CNT_W-1:0]      wdata;

	assign in_idx = item.block_id[IDX_W-1:0];

	// lowest pending entry of the dump
	assign low_bit   = present_q & (~present_q + NUM_BLOCKS'(1));
	assign pend_rest = present_q & ~low_bit;

	always_comb begin
		scan_idx = '0;
		for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
			if (present_q[i]) begin
				scan_idx = IDX_W'(i);
			end
		end
	end

	assign re    = dcmd.load_ev | dcmd.scan;
	assign raddr = dcmd.scan ? scan_idx : in_idx;
	assign wdata = (ev_pres_q ? rdata : '0) + CNT_W'(ev_cnt_q);

	bbvic_ram #(
		.WIDTH(CNT_W),
		.DEPTH(NUM_BLOCKS)
	) u_hist (
		.clk  (clk),
		.we   (dcmd.write_ev),
		.waddr(ev_id_q),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q  <= INTERVAL_RESET;
			total_q   <= '0;
			inum_q    <= '0;
			present_q <= '0;
			strobe_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				length_q <= cfg_data;
			end
			if (dcmd.load_ev) begin
				total_q <= total_q + CNT_W'(item.insn_count);
			end
			if (dcmd.write_ev) begin
				present_q[ev_id_q] <= 1'b1;
			end
			if (dcmd.scan) begin
				present_q <= pend_rest;
			end
			if (dcmd.finish) begin
				total_q <= '0;
				inum_q  <= inum_q + INUM_W'(1);
			end
			strobe_s1 <= dcmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.load_ev) begin
			ev_id_q   <= in_idx;
			ev_cnt_q  <= item.insn_count;
			ev_pres_q <= present_q[in_idx];
		end
		if (dcmd.scan) begin
			id_s1   <= ID_W'(scan_idx);
			last_s1 <= (pend_rest == '0);
			inum_s1 <= inum_q;
		end
	end

	assign sts.id_in_range = ({1'b0, item.block_id} < (ID_W + 1)'(NUM_BLOCKS));
	assign sts.any_present = |present_q;
	assign sts.reached     = (total_q >= CNT_W'(length_q));
	assign sts.scan_last   = (pend_rest == '0);

	assign length                 = length_q;
	assign strobe                 = strobe_s1;
	assign result.interval_number = inum_s1;
	assign result.entry_id        = id_s1;
	assign result.entry_count     = rdata;
	assign result.last_entry      = last_s1;

endmodule

>>> hdl/basic_block_vector_interval_counter_unit.sv
// Top level of the basic block vector interval counter with its APB register port.
//
//   channel  handshake              payload
//   input    start & !busy          item   (cmd, block_id, insn_count)
//   result   strobe, one cycle      result (interval_number, entry_id, entry_count, last_entry)
//   config   psel&penable&pwrite    pwdata[39:0] -> interval_length at paddr 0
//
// An in-range event is a histogram read, then a write back and total check;
// an out-of-range event or a finish with an empty histogram is taken without leaving idle.
// A dump reads one present entry per cycle, set by the single histogram read port;
// each result beat appears in the cycle after its entry is read.
// Reset clears the present flags, total and interval number; the store needs no sweep.
// Results cannot be stalled by the receiver.
module basic_block_vector_interval_counter_unit
	import bbvic_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              strobe,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	dp_cmd_t          dcmd;
	dp_sts_t          sts;
	logic             cfg_we;
	logic [LEN_W-1:0] length;
	logic             reg_sel;

	// register index is the 8-byte word address
	assign reg_sel = (paddr[APB_AW-1] == REG_INTERVAL_LENGTH);
	assign cfg_we  = psel & penable & pwrite & reg_sel;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? APB_DW'(length) : '0;

	bbvic_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (item.cmd),
		.sts   (sts),
		.busy  (busy),
		.dcmd  (dcmd)
	);

	bbvic_dp #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.dcmd    (dcmd),
		.cfg_we  (cfg_we),
		.cfg_data(pwdata[LEN_W-1:0]),
		.length  (length),
		.sts     (sts),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the basic block vector interval counter.
module testbench
	import bbvic_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_LIMIT  = 4000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS   = 40;

	localparam logic [APB_AW-1:0] LEN_ADDR   = APB_AW'({REG_INTERVAL_LENGTH, 3'b000});
	localparam logic [APB_AW-1:0] SPARE_ADDR = 4'h8;
	localparam logic [APB_AW-1:0] TOP_ADDR   = 4'hF;
	localparam logic [LEN_W-1:0]  LEN_MAX    = '1;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              start   = 1'b0;
	logic              busy;
	item_t             item    = '0;
	logic              strobe;
	result_t           result;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	basic_block_vector_interval_counter_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.strobe  (strobe),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Shadow copy of the block state
	logic [CNT_W-1:0]  hist_count [NUM_BLOCKS_DEF];
	logic              hist_seen  [NUM_BLOCKS_DEF];
	logic [CNT_W-1:0]  run_total;
	logic [INUM_W-1:0] interval_no;
	logic [LEN_W-1:0]  len_cfg;

	item_t   event_queue[$];
	result_t expected_entries[$];
	int      fail_count = 0;
	int      cycle_count = 0;
	int      gap_left = 0;
	logic    item_taken = 1'b0;

	function automatic bit take_fail_slot();
		fail_count++;
		return fail_count <= 10;
	endfunction

	function automatic void clear_histogram();
		for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
			hist_count[i] = '0;
			hist_seen[i]  = 1'b0;
		end
		run_total = '0;
	endfunction

	function automatic void emit_histogram();
		int      last_id;
		result_t r;
		last_id = -1;
		for (int i = 0; i < NUM_BLOCKS_DEF; i++)
			if (hist_seen[i])
				last_id = i;
		for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
			if (hist_seen[i]) begin
				r.interval_number = interval_no;
				r.entry_id        = ID_W'(i);
				r.entry_count     = hist_count[i];
				r.last_entry      = (i == last_id);
				expected_entries.push_back(r);
			end
		end
		clear_histogram();
		interval_no = interval_no + 1'b1;
	endfunction

	function automatic void count_event(item_t it);
		bit any;
		int id;
		any = 1'b0;
		id  = int'(it.block_id);
		if (it.cmd == CMD_FINISH) begin
			for (int i = 0; i < NUM_BLOCKS_DEF; i++)
				any |= hist_seen[i];
			if (any)
				emit_histogram();
		end else if (id < NUM_BLOCKS_DEF) begin
			hist_count[id] = hist_count[id] + CNT_W'(it.insn_count);
			hist_seen[id]  = 1'b1;
			run_total      = run_total + CNT_W'(it.insn_count);
			if (run_total >= CNT_W'(len_cfg))
				emit_histogram();
		end
	endfunction

	function automatic item_t ev(int id, int cnt);
		item_t it;
		it.cmd        = CMD_EVENT;
		it.block_id   = ID_W'(id);
		it.insn_count = INSN_W'(cnt);
		return it;
	endfunction

	function automatic item_t fin(int id, int cnt);
		item_t it;
		it.cmd        = CMD_FINISH;
		it.block_id   = ID_W'(id);
		it.insn_count = INSN_W'(cnt);
		return it;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int rand_count();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 4095;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	// Driver: hold the beat until taken, then idle for a random gap
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !item_taken) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			start    <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (event_queue.size() != 0) begin
			item     <= event_queue.pop_front();
			start    <= 1'b1;
			gap_left <= pick_gap();
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: check result beats, then predict from accepted beats
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (strobe) begin
				if (expected_entries.size() == 0) begin
					if (take_fail_slot())
						$display("unexpected result: num=%0d id=%0d count=%0d last=%0b",
							result.interval_number, result.entry_id, result.entry_count,
							result.last_entry);
				end else begin
					want = expected_entries.pop_front();
					if (result.interval_number !== want.interval_number ||
					    result.entry_id !== want.entry_id ||
					    result.entry_count !== want.entry_count ||
					    result.last_entry !== want.last_entry) begin
						if (take_fail_slot())
							$display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
								want.interval_number, want.entry_id, want.entry_count,
								want.last_entry, result.interval_number, result.entry_id,
								result.entry_count, result.last_entry);
					end
				end
			end
			if (start && !busy)
				count_event(item);
			item_taken <= start && !busy;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == LEN_ADDR)
			len_cfg = data[LEN_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read_length();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= LEN_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[LEN_W-1:0] !== len_cfg) begin
			if (take_fail_slot())
				$display("register read: exp %0d got %0d", len_cfg, prdata[LEN_W-1:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_length(logic [LEN_W-1:0] len);
		apb_write(LEN_ADDR, {$urandom, $urandom} & ~{{(APB_DW-LEN_W){1'b0}}, LEN_MAX} |
			{{(APB_DW-LEN_W){1'b0}}, len});
		apb_read_length();
	endtask

	// Wait for every beat to be taken and every result to arrive, then let the block go idle
	task automatic drain_phase();
		int waited;
		waited = 0;
		while (event_queue.size() != 0 || start)
			@(posedge clk);
		while (expected_entries.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
		if (expected_entries.size() != 0) begin
			fail_count += expected_entries.size();
			expected_entries.delete();
		end
	endtask

	task automatic fill_random(int n);
		int roll;
		int id;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				event_queue.push_back(fin($urandom_range(0, 63), $urandom_range(0, 4095)));
			end else begin
				id = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63);
				event_queue.push_back(ev(id, rand_count()));
			end
		end
	endtask

	initial begin
		logic [LEN_W-1:0] len;
		clear_histogram();
		interval_no = '0;
		len_cfg     = INTERVAL_RESET;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		apb_read_length();

		// Default length: zero count, extreme ids and counts, flush, empty flush
		event_queue.push_back(ev(0, 0));
		event_queue.push_back(ev(63, 4095));
		event_queue.push_back(ev(0, 4095));
		event_queue.push_back(ev(21, 1));
		event_queue.push_back(fin(0, 0));
		event_queue.push_back(fin(63, 4095));
		event_queue.push_back(ev(42, 2730));
		event_queue.push_back(ev(21, 1365));
		drain_phase();

		// Lower the length with counts still held; ignore junk addresses
		apb_write(SPARE_ADDR, {$urandom, $urandom});
		apb_write(TOP_ADDR, '1);
		apb_write(LEN_ADDR, {{(APB_DW-LEN_W){1'b1}}, LEN_W'(5)});
		apb_read_length();
		event_queue.push_back(ev(7, 0));
		event_queue.push_back(ev(1, 3));
		event_queue.push_back(ev(1, 2));
		drain_phase();

		// Zero length: every event dumps at once
		set_length('0);
		event_queue.push_back(ev(63, 0));
		event_queue.push_back(ev(5, 9));
		event_queue.push_back(fin(0, 0));
		drain_phase();

		set_length(LEN_MAX);
		event_queue.push_back(ev(0, 4095));
		event_queue.push_back(ev(63, 4095));
		event_queue.push_back(ev(32, 0));
		event_queue.push_back(ev(0, 100));
		event_queue.push_back(fin(42, 2730));
		drain_phase();

		set_length(LEN_W'(1));
		event_queue.push_back(ev(10, 0));
		event_queue.push_back(ev(11, 1));
		drain_phase();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 4))
				0: len = LEN_W'($urandom_range(1, 4095));
				1: len = LEN_W'($urandom_range(4096, 60000));
				2: len = LEN_W'($urandom_range(0, 2));
				3: len = LEN_MAX;
				default: len = LEN_W'($urandom_range(20000, 200000));
			endcase
			if ($urandom_range(0, 1))
				apb_write(SPARE_ADDR, {$urandom, $urandom});
			set_length(len);
			fill_random(PHASE_ITEMS);
			drain_phase();
		end

		event_queue.push_back(fin(0, 0));
		drain_phase();

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
